### src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

	localparam int CFG_W   = 10;
	localparam int CIDX_W  = 3;
	localparam int OP_W    = 2;

	// command codes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_RESET = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CIDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CIDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_ONE_LOW       = 3'd3;
	localparam logic [CIDX_W-1:0] REG_ONE_HIGH      = 3'd4;
	localparam logic [CIDX_W-1:0] REG_ZERO_LOW      = 3'd5;
	localparam logic [CIDX_W-1:0] REG_ZERO_HIGH     = 3'd6;

	// register reset values
	localparam logic [CFG_W-1:0] DEF_RESET_LOW     = 10'd480;
	localparam logic [CFG_W-1:0] DEF_PRESENCE_WAIT = 10'd70;
	localparam logic [CFG_W-1:0] DEF_RESET_TAIL    = 10'd410;
	localparam logic [CFG_W-1:0] DEF_ONE_LOW       = 10'd10;
	localparam logic [CFG_W-1:0] DEF_ONE_HIGH      = 10'd55;
	localparam logic [CFG_W-1:0] DEF_ZERO_LOW      = 10'd65;
	localparam logic [CFG_W-1:0] DEF_ZERO_HIGH     = 10'd5;

	// fixed read slot timing
	localparam logic [CFG_W-1:0] RD_LOW_TICKS  = 10'd3;
	localparam logic [CFG_W-1:0] RD_WAIT_TICKS = 10'd10;
	localparam logic [CFG_W-1:0] RD_TAIL_TICKS = 10'd50;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low;
		logic [CFG_W-1:0] presence_wait;
		logic [CFG_W-1:0] reset_tail;
		logic [CFG_W-1:0] one_low;
		logic [CFG_W-1:0] one_high;
		logic [CFG_W-1:0] zero_low;
		logic [CFG_W-1:0] zero_high;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [7:0]      data_byte;
		logic            line_level;
	} item_t;

	typedef struct packed {
		logic       rejected;
		logic [7:0] read_data;
		logic       presence_detected;
		logic       done_res;
		logic       busy_res;
		logic       drive_level;
		logic       drive_enable;
	} result_t;

endpackage

`default_nettype wire

### src/owbm_cfg.sv
// ----------------------------------------------------------------------------
// owbm_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [owbm_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [owbm_pkg::CFG_W-1:0]  cfg_data,
	output owbm_pkg::cfg_t                  cfg
);
	import owbm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= DEF_RESET_LOW;
			cfg_q.presence_wait <= DEF_PRESENCE_WAIT;
			cfg_q.reset_tail    <= DEF_RESET_TAIL;
			cfg_q.one_low       <= DEF_ONE_LOW;
			cfg_q.one_high      <= DEF_ONE_HIGH;
			cfg_q.zero_low      <= DEF_ZERO_LOW;
			cfg_q.zero_high     <= DEF_ZERO_HIGH;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_RESET_LOW:     cfg_q.reset_low     <= cfg_data;
				REG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data;
				REG_RESET_TAIL:    cfg_q.reset_tail    <= cfg_data;
				REG_ONE_LOW:       cfg_q.one_low       <= cfg_data;
				REG_ONE_HIGH:      cfg_q.one_high      <= cfg_data;
				REG_ZERO_LOW:      cfg_q.zero_low      <= cfg_data;
				REG_ZERO_HIGH:     cfg_q.zero_high     <= cfg_data;
				default: ;  // no register there
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/owbm_core.sv
// ----------------------------------------------------------------------------
// owbm_core
// Phase sequencer: one item per step updates timer, phase, line drive and
// shift state, and gives the result of that item.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_core #(
	parameter int TIMER_BITS = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire owbm_pkg::item_t item,
	input  wire owbm_pkg::cfg_t  cfg,
	output owbm_pkg::result_t    res
);
	import owbm_pkg::*;

	localparam int VW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_TAIL = 4'd3;
	localparam logic [3:0] PH_WR_LOW   = 4'd4;
	localparam logic [3:0] PH_WR_HIGH  = 4'd5;
	localparam logic [3:0] PH_RD_LOW   = 4'd6;
	localparam logic [3:0] PH_RD_WAIT  = 4'd7;
	localparam logic [3:0] PH_RD_TAIL  = 4'd8;

	// phase length: zero acts as one, saturate at the timer maximum
	function automatic logic [TIMER_BITS-1:0] load_len(input logic [CFG_W-1:0] v);
		logic [VW-1:0] ext;
		ext = VW'(v);
		if (ext == '0)
			ext = VW'(1);
		else if (ext > VW'(TMAX))
			ext = VW'(TMAX);
		return TIMER_BITS'(ext);
	endfunction

	logic [3:0]            ph_q, ph_n;
	logic [TIMER_BITS-1:0] tmr_q, tmr_n;
	logic [2:0]            bit_q, bit_n;
	logic [7:0]            shift_q, shift_n;
	logic                  pres_q, pres_n;
	logic                  de_q, de_n;
	logic                  dl_q, dl_n;
	logic [7:0]            rd_q, rd_n;
	logic                  done, rej;

	always_comb begin
		ph_n    = ph_q;
		tmr_n   = tmr_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		pres_n  = pres_q;
		de_n    = de_q;
		dl_n    = dl_q;
		rd_n    = rd_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (item.operation == OP_TICK) begin
			if (ph_q != PH_IDLE) begin
				if (tmr_q[TIMER_BITS-1:1] == '0) begin
					tmr_n = '0;
					unique case (ph_q)
						PH_RST_LOW: begin
							de_n  = 1'b0;
							ph_n  = PH_RST_WAIT;
							tmr_n = load_len(cfg.presence_wait);
						end
						PH_RST_WAIT: begin
							pres_n = ~item.line_level;
							ph_n   = PH_RST_TAIL;
							tmr_n  = load_len(cfg.reset_tail);
						end
						PH_RST_TAIL: begin
							ph_n = PH_IDLE;
							done = 1'b1;
						end
						PH_WR_LOW: begin
							de_n  = 1'b1;
							dl_n  = 1'b1;
							ph_n  = PH_WR_HIGH;
							tmr_n = load_len(shift_q[0] ? cfg.one_high : cfg.zero_high);
						end
						PH_WR_HIGH: begin
							shift_n = {1'b0, shift_q[7:1]};
							if (bit_q == LAST_BIT) begin
								ph_n = PH_IDLE;
								done = 1'b1;
							end else begin
								bit_n = bit_q + 3'd1;
								de_n  = 1'b1;
								dl_n  = 1'b0;
								ph_n  = PH_WR_LOW;
								// next slot uses the bit just shifted down
								tmr_n = load_len(shift_q[1] ? cfg.one_low : cfg.zero_low);
							end
						end
						PH_RD_LOW: begin
							de_n  = 1'b0;
							ph_n  = PH_RD_WAIT;
							tmr_n = load_len(RD_WAIT_TICKS);
						end
						PH_RD_WAIT: begin
							shift_n = {item.line_level, shift_q[7:1]};
							ph_n    = PH_RD_TAIL;
							tmr_n   = load_len(RD_TAIL_TICKS);
						end
						PH_RD_TAIL: begin
							if (bit_q == LAST_BIT) begin
								rd_n = shift_q;
								ph_n = PH_IDLE;
								done = 1'b1;
							end else begin
								bit_n = bit_q + 3'd1;
								de_n  = 1'b1;
								dl_n  = 1'b0;
								ph_n  = PH_RD_LOW;
								tmr_n = load_len(RD_LOW_TICKS);
							end
						end
						default: ph_n = PH_IDLE;
					endcase
				end else begin
					tmr_n = tmr_q - TIMER_BITS'(1);
				end
			end
		end else if (ph_q != PH_IDLE) begin
			rej = 1'b1;
		end else begin
			bit_n = '0;
			de_n  = 1'b1;
			dl_n  = 1'b0;
			unique case (item.operation)
				OP_RESET: begin
					ph_n  = PH_RST_LOW;
					tmr_n = load_len(cfg.reset_low);
				end
				OP_WRITE: begin
					shift_n = item.data_byte;
					ph_n    = PH_WR_LOW;
					tmr_n   = load_len(item.data_byte[0] ? cfg.one_low : cfg.zero_low);
				end
				default: begin
					shift_n = '0;
					ph_n    = PH_RD_LOW;
					tmr_n   = load_len(RD_LOW_TICKS);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			tmr_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			de_q    <= 1'b0;
			dl_q    <= 1'b1;
			rd_q    <= '0;
		end else if (step) begin
			ph_q    <= ph_n;
			tmr_q   <= tmr_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
			de_q    <= de_n;
			dl_q    <= dl_n;
			rd_q    <= rd_n;
		end
	end

	assign res.drive_enable      = de_n;
	assign res.drive_level       = de_n & dl_n;
	assign res.busy_res          = (ph_n != PH_IDLE);
	assign res.done_res          = done;
	assign res.presence_detected = pres_n;
	assign res.read_data         = rd_n;
	assign res.rejected          = rej;

endmodule

`default_nettype wire

### src/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by one-microsecond tick transfers.
// ----------------------------------------------------------------------------
// Every input transfer (tick, bus reset, write byte or read byte) yields
// exactly one result transfer with the line drive and status after it. The
// block takes one transfer per clock while the result side keeps up: an
// input register feeds the phase sequencer, whose combinational update loads
// the result register, and a stalled result side holds both registers.
// Commands that arrive while a sequence runs are ignored and flagged as
// rejected. Timing registers are to be written by the user through the cfg
// port only while no transfer is in flight; the block itself does not enforce
// it. A change made during a sequence applies from the next phase loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master #(
	parameter int TIMER_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,   // [7:0] data_byte, [8] line_level
	input  wire logic [1:0]                  s_tuser,   // [1:0] operation
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res,
	// [4] presence_detected, [12:5] read_data, [13] rejected
	output logic [15:0]                      m_tdata,
	input  wire logic                        cfg_wen,
	input  wire logic [owbm_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [owbm_pkg::CFG_W-1:0]  cfg_data
);
	import owbm_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	logic    out_valid_q;
	result_t out_q;
	logic    step;

	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation  <= s_tuser;
			item_s1.data_byte  <= s_tdata[7:0];
			item_s1.line_level <= s_tdata[8];
		end
	end

	owbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owbm_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || m_tready)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire

### src/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// finishing transfer reports idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done while busy");

	// released line never reports a driven level
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("drive level without drive enable");

	// a command is rejected only while a sequence runs
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[2] && !m_tdata[3])
		else $error("rejected while idle or done");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### bench/one_wire_bus_master_checker.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_checker
// Status predictor and result checker for the 1-Wire bus master.
// ----------------------------------------------------------------------------
// Watches the config port and both stream channels. Each accepted input
// transfer runs through a local copy of the phase sequencer and queues the
// expected status. Each accepted result transfer is compared field by field
// with the oldest queued status. The failure count, the number of statuses
// still owed and the predicted busy state go back to the test top.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [15:0]                 s_tdata,   // [7:0] data_byte, [8] line_level
	input  wire logic [1:0]                  s_tuser,   // [1:0] operation
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	// [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res,
	// [4] presence_detected, [12:5] read_data, [13] rejected
	input  wire logic [15:0]                 m_tdata,
	input  wire logic                        cfg_wen,
	input  wire logic [owbm_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [owbm_pkg::CFG_W-1:0]  cfg_data,
	output int                               fails,
	output int                               pending,
	output logic                             busy
);
	import owbm_pkg::*;

	localparam int NUM_TIMINGS = 7;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_WR_LOW,
		PH_WR_HIGH,
		PH_RD_LOW,
		PH_RD_WAIT,
		PH_RD_TAIL
	} bus_phase_t;

	logic [CFG_W-1:0] timing [NUM_TIMINGS];
	bus_phase_t       bus_phase;
	logic [CFG_W-1:0] slot_timer;
	logic [2:0]       bit_cnt;
	logic [7:0]       shift_reg;
	logic             presence_seen;
	logic             drv_en;
	logic             drv_lvl;
	logic [7:0]       rd_byte;

	result_t status_q[$];
	int      fail_cnt = 0;
	int      owed_cnt = 0;

	assign fails   = fail_cnt;
	assign pending = owed_cnt;
	assign busy    = (bus_phase != PH_IDLE);

	task clear_bus_state();
		timing[REG_RESET_LOW]     = DEF_RESET_LOW;
		timing[REG_PRESENCE_WAIT] = DEF_PRESENCE_WAIT;
		timing[REG_RESET_TAIL]    = DEF_RESET_TAIL;
		timing[REG_ONE_LOW]       = DEF_ONE_LOW;
		timing[REG_ONE_HIGH]      = DEF_ONE_HIGH;
		timing[REG_ZERO_LOW]      = DEF_ZERO_LOW;
		timing[REG_ZERO_HIGH]     = DEF_ZERO_HIGH;
		bus_phase     = PH_IDLE;
		slot_timer    = '0;
		bit_cnt       = '0;
		shift_reg     = '0;
		presence_seen = 1'b0;
		drv_en        = 1'b0;
		drv_lvl       = 1'b1;
		rd_byte       = '0;
	endtask

	// a zero length runs one tick; 10-bit timings never exceed the timer range
	task load_phase(input bus_phase_t ph, input logic [CFG_W-1:0] ticks);
		bus_phase  = ph;
		slot_timer = (ticks == '0) ? CFG_W'(1) : ticks;
	endtask

	task go_idle();
		bus_phase  = PH_IDLE;
		slot_timer = '0;
	endtask

	task start_write_slot();
		drv_en  = 1'b1;
		drv_lvl = 1'b0;
		load_phase(PH_WR_LOW, shift_reg[0] ? timing[REG_ONE_LOW] : timing[REG_ZERO_LOW]);
	endtask

	task start_read_slot();
		drv_en  = 1'b1;
		drv_lvl = 1'b0;
		load_phase(PH_RD_LOW, RD_LOW_TICKS);
	endtask

	task end_phase(input logic line, output logic finished);
		finished = 1'b0;
		case (bus_phase)
		PH_RST_LOW: begin
			drv_en = 1'b0;
			load_phase(PH_RST_WAIT, timing[REG_PRESENCE_WAIT]);
		end
		PH_RST_WAIT: begin
			// a device answers by pulling the line low
			presence_seen = !line;
			load_phase(PH_RST_TAIL, timing[REG_RESET_TAIL]);
		end
		PH_RST_TAIL: begin
			go_idle();
			finished = 1'b1;
		end
		PH_WR_LOW: begin
			drv_en  = 1'b1;
			drv_lvl = 1'b1;
			load_phase(PH_WR_HIGH, shift_reg[0] ? timing[REG_ONE_HIGH] : timing[REG_ZERO_HIGH]);
		end
		PH_WR_HIGH: begin
			shift_reg = shift_reg >> 1;
			if (bit_cnt == LAST_BIT) begin
				go_idle();
				finished = 1'b1;
			end else begin
				bit_cnt = bit_cnt + 3'd1;
				start_write_slot();
			end
		end
		PH_RD_LOW: begin
			drv_en = 1'b0;
			load_phase(PH_RD_WAIT, RD_WAIT_TICKS);
		end
		PH_RD_WAIT: begin
			shift_reg = {line, shift_reg[7:1]};
			load_phase(PH_RD_TAIL, RD_TAIL_TICKS);
		end
		PH_RD_TAIL: begin
			if (bit_cnt == LAST_BIT) begin
				rd_byte = shift_reg;
				go_idle();
				finished = 1'b1;
			end else begin
				bit_cnt = bit_cnt + 3'd1;
				start_read_slot();
			end
		end
		default: begin
			go_idle();
		end
		endcase
	endtask

	task predict_status(input item_t it, output result_t st);
		logic finished;
		finished = 1'b0;
		st       = '0;
		if (it.operation == OP_TICK) begin
			if (bus_phase != PH_IDLE) begin
				if (slot_timer <= CFG_W'(1)) begin
					slot_timer = '0;
					end_phase(it.line_level, finished);
				end else begin
					slot_timer = slot_timer - CFG_W'(1);
				end
			end
		end else if (bus_phase != PH_IDLE) begin
			st.rejected = 1'b1;
		end else begin
			bit_cnt = '0;
			case (it.operation)
			OP_RESET: begin
				drv_en  = 1'b1;
				drv_lvl = 1'b0;
				load_phase(PH_RST_LOW, timing[REG_RESET_LOW]);
			end
			OP_WRITE: begin
				shift_reg = it.data_byte;
				start_write_slot();
			end
			default: begin
				shift_reg = '0;
				start_read_slot();
			end
			endcase
		end
		st.drive_enable      = drv_en;
		st.drive_level       = drv_en & drv_lvl;
		st.busy_res          = (bus_phase != PH_IDLE);
		st.done_res          = finished;
		st.presence_detected = presence_seen;
		st.read_data         = rd_byte;
	endtask

	task check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t want;
		result_t seen;
		if (!arst_n) begin
			clear_bus_state();
			status_q.delete();
			owed_cnt = 0;
		end else begin
			if (cfg_wen && cfg_index < NUM_TIMINGS)
				timing[cfg_index] = cfg_data;
			if (m_tvalid && m_tready) begin
				seen = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (status_q.size() == 0) begin
					$error("result transfer with no status expected");
					fail_cnt++;
				end else begin
					want = status_q.pop_front();
					check_field("drive_enable", int'(want.drive_enable),
						int'(seen.drive_enable));
					check_field("drive_level", int'(want.drive_level),
						int'(seen.drive_level));
					check_field("busy_res", int'(want.busy_res), int'(seen.busy_res));
					check_field("done_res", int'(want.done_res), int'(seen.done_res));
					check_field("presence_detected", int'(want.presence_detected),
						int'(seen.presence_detected));
					check_field("read_data", int'(want.read_data), int'(seen.read_data));
					check_field("rejected", int'(want.rejected), int'(seen.rejected));
				end
			end
			if (s_tvalid && s_tready) begin
				it.operation  = s_tuser;
				it.data_byte  = s_tdata[7:0];
				it.line_level = s_tdata[8];
				predict_status(it, want);
				status_q.push_back(want);
			end
			owed_cnt = status_q.size();
		end
	end

endmodule

`default_nettype wire

### bench/one_wire_bus_master_test.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_test
// Stimulus and verdict for the 1-Wire bus master.
// ----------------------------------------------------------------------------
// Drives bus reset, write and read commands followed by tick transfers until
// the predicted sequence ends, with rejected commands and idle ticks mixed
// in. A directed part covers a write at the reset timings, zero timings, an
// unused register index and a timing change in the middle of a write. The
// random part uses mostly short timings so that many commands complete. Both
// stream sides pause at random until the last stretch of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_test;
	import owbm_pkg::*;

	localparam logic [CIDX_W-1:0] REG_UNUSED   = 3'd7;
	localparam logic [CFG_W-1:0]  TIMING_MAX   = 10'd1023;
	localparam int                RANDOM_ITEMS = 400;
	localparam int                CALM_ITEMS   = 330;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata   = '0;
	logic [1:0]        s_tuser   = OP_TICK;
	logic              m_tvalid;
	logic              m_tready  = 1'b1;
	logic [15:0]       m_tdata;
	logic              cfg_wen   = 1'b0;
	logic [CIDX_W-1:0] cfg_index = REG_RESET_LOW;
	logic [CFG_W-1:0]  cfg_data  = '0;

	int   fails;
	int   pending;
	logic busy;
	logic calm       = 1'b0;
	int   work_items = 0;
	int   cmd_cnt    = 0;

	one_wire_bus_master u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	one_wire_bus_master_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.busy      (busy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side stalls
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#30_000_000;
		$display("FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the transfer
	// with valid still high, so the caller either sends again or quiesces
	task send(input logic [OP_W-1:0] op, input logic [7:0] dat, input logic lvl);
		if (op != OP_TICK || busy)
			work_items++;
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, lvl, dat};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task tick_until_idle(input bit fix_line, input logic line_val, input bit noisy);
		while (busy) begin
			if (noisy && $urandom_range(0, 49) == 0)
				send(OP_W'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
			else
				send(OP_TICK, 8'($urandom), fix_line ? line_val : 1'($urandom));
		end
	endtask

	task run_command(input logic [OP_W-1:0] op, input logic [7:0] dat,
			input bit fix_line, input logic line_val, input bit noisy);
		send(op, dat, fix_line ? line_val : 1'($urandom));
		tick_until_idle(fix_line, line_val, noisy);
	endtask

	// wait out every owed status, then let the last results drain from the block
	task quiesce();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// leaves the write enable high; the caller lowers it after the last write
	task write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task set_timings(input logic [CFG_W-1:0] rst_low, input logic [CFG_W-1:0] pres_wait,
			input logic [CFG_W-1:0] rst_tail, input logic [CFG_W-1:0] one_low,
			input logic [CFG_W-1:0] one_high, input logic [CFG_W-1:0] zero_low,
			input logic [CFG_W-1:0] zero_high);
		quiesce();
		write_reg(REG_RESET_LOW, rst_low);
		write_reg(REG_PRESENCE_WAIT, pres_wait);
		write_reg(REG_RESET_TAIL, rst_tail);
		write_reg(REG_ONE_LOW, one_low);
		write_reg(REG_ONE_HIGH, one_high);
		write_reg(REG_ZERO_LOW, zero_low);
		write_reg(REG_ZERO_HIGH, zero_high);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_timing();
		if ($urandom_range(0, 7) == 0)
			return CFG_W'($urandom_range(4, 40));
		return CFG_W'($urandom_range(0, 3));
	endfunction

	initial begin
		int pick;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ticks while idle change nothing
		send(OP_TICK, 8'h00, 1'b0);
		send(OP_TICK, 8'hFF, 1'b1);

		// write at the reset timings; commands during a sequence get rejected
		send(OP_WRITE, 8'hA5, 1'b0);
		send(OP_READ, 8'h00, 1'b1);
		send(OP_RESET, 8'h55, 1'b0);
		send(OP_WRITE, 8'hFF, 1'b0);
		tick_until_idle(1'b0, 1'b0, 1'b0);

		// zero timings run as one tick each
		set_timings('0, '0, '0, '0, '0, '0, '0);
		run_command(OP_RESET, 8'h00, 1'b1, 1'b1, 1'b0);
		run_command(OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b0);
		run_command(OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
		run_command(OP_READ, 8'h00, 1'b1, 1'b1, 1'b0);
		run_command(OP_READ, 8'hFF, 1'b1, 1'b0, 1'b0);

		// unused register index is dropped
		quiesce();
		write_reg(REG_UNUSED, TIMING_MAX);
		cfg_wen <= 1'b0;
		run_command(OP_RESET, 8'h00, 1'b1, 1'b0, 1'b0);

		// timing change mid-write takes effect from the next phase loaded
		set_timings(10'd2, 10'd2, 10'd2, 10'd1, 10'd3, 10'd2, 10'd1);
		send(OP_WRITE, 8'h3C, 1'b0);
		repeat (3) send(OP_TICK, 8'($urandom), 1'($urandom));
		quiesce();
		write_reg(REG_ONE_HIGH, 10'd7);
		write_reg(REG_ZERO_LOW, 10'd1);
		cfg_wen <= 1'b0;
		tick_until_idle(1'b0, 1'b0, 1'b0);

		work_items = 0;
		while (work_items < RANDOM_ITEMS) begin
			if (cmd_cnt % 12 == 0)
				set_timings(pick_timing(), pick_timing(), pick_timing(), pick_timing(),
					pick_timing(), pick_timing(), pick_timing());
			if (work_items >= CALM_ITEMS)
				calm = 1'b1;
			cmd_cnt++;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				run_command(OP_RESET, 8'($urandom), 1'b0, 1'b0, 1'b1);
			else if (pick < 75)
				run_command(OP_WRITE, 8'($urandom), 1'b0, 1'b0, 1'b1);
			else if (pick < 88)
				run_command(OP_READ, 8'($urandom), 1'b0, 1'b0, 1'b1);
			else
				send(OP_TICK, 8'($urandom), 1'($urandom));
		end

		calm = 1'b1;
		quiesce();
		repeat (10) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
src/owbm_pkg.sv
src/owbm_cfg.sv
src/owbm_core.sv
src/one_wire_bus_master.sv
src/owbm_checker.sv
bench/one_wire_bus_master_checker.sv
bench/one_wire_bus_master_test.sv
